>>> hdl/sctm_pkg.sv
// Shared types and constants of the compare timer multiplexer.
package sctm_pkg;

    // Request operation codes
    localparam logic OP_SET = 1'b0;
    localparam logic OP_IRQ = 1'b1;

    // Result kinds
    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_CMP  = 1'b1;

    // Configuration register indexes, taken from address bit REG_IDX_BIT
    localparam logic REG_ONLINE_MASK    = 1'b0;
    localparam logic REG_SLOT_GROUP_MAP = 1'b1;
    localparam int   REG_IDX_BIT        = 2;
    localparam int   APB_ADDR_W         = 3;
    localparam int   APB_DATA_W         = 32;

    // Register reset values
    localparam logic [7:0] ONLINE_MASK_RESET = 8'hFF;
    localparam logic [7:0] GROUP_MAP_RESET   = 8'h00;

    // One timer request
    typedef struct packed {
        logic        op;
        logic        group;
        logic [2:0]  slot;
        logic [31:0] delta;
        logic [31:0] now;
        logic        timer_pending;
    } req_t;

    // One result
    typedef struct packed {
        logic        kind;
        logic [2:0]  target_slot;
        logic        by_ipi;
        logic [31:0] compare_value;
        logic        last;
    } res_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [7:0] online_mask;
        logic [7:0] slot_group_map;
    } cfg_t;

    // Outputs of the shared compare unit
    typedef struct packed {
        logic [31:0] rel;
        logic        lt;
        logic        gt;
    } cmp_t;

endpackage

>>> hdl/sctm_if.sv
// Valid/ready channel interfaces for requests and results.
interface sctm_req_if import sctm_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sctm_res_if import sctm_pkg::*; ();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/sctm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sctm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sctm_apb_regs.sv
// APB configuration registers: online mask and slot-to-group map.
module sctm_apb_regs import sctm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [7:0] online_mask_reg;
    logic [7:0] group_map_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_mask_reg <= ONLINE_MASK_RESET;
            group_map_reg   <= GROUP_MAP_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[REG_IDX_BIT])
                REG_ONLINE_MASK:    online_mask_reg <= pwdata[7:0];
                REG_SLOT_GROUP_MAP: group_map_reg   <= pwdata[7:0];
                default:            online_mask_reg <= online_mask_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[REG_IDX_BIT])
            REG_ONLINE_MASK:    prdata = APB_DATA_W'(online_mask_reg);
            REG_SLOT_GROUP_MAP: prdata = APB_DATA_W'(group_map_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.online_mask    = online_mask_reg;
    assign cfg.slot_group_map = group_map_reg;

endmodule

>>> hdl/sctm_cmp_unit.sv
// Shared wraparound compare unit: distance of an entry from now against a base distance.
module sctm_cmp_unit import sctm_pkg::*; (
    input  logic [31:0] operand,
    input  logic [31:0] now,
    input  logic [31:0] base_rel,
    output cmp_t        result
);

    logic [31:0] rel;

    // Distance ahead of now, modulo 2^32
    assign rel = operand - now;

    assign result.rel = rel;
    assign result.lt  = rel < base_rel;
    assign result.gt  = base_rel < rel;

endmodule

>>> hdl/shared_compare_timer_multiplexer_unit.sv
// A set request writes the slot's new deadline and emits a compare value if it is now the
// soonest, or rescans the group if the soonest slot is postponed; an interrupt request scans
// its group. One request is worked at a time, and each scan reads one table entry per cycle,
// unless a result stall holds it, from the deadline RAM into the one shared compare unit.
// Reset is asynchronous and active low; the deadline table reads as empty at once through
// per-entry valid flops, the soonest slots clear to zero, and no clearing pass is needed.
module shared_compare_timer_multiplexer_unit import sctm_pkg::*; #(
    parameter int NUM_SLOTS  = 8,
    parameter int NUM_GROUPS = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sctm_req_if.sink              req,
    sctm_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int CW    = $clog2(NUM_SLOTS + 1);
    localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int DEPTH = NUM_GROUPS * NUM_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SET_RDP = 3'd1;
    localparam logic [2:0] ST_SET_RDC = 3'd2;
    localparam logic [2:0] ST_SET_DEC = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_FLUSH   = 3'd5;

    function automatic logic [AW-1:0] ent_addr(input logic [GW-1:0] g, input logic [SW-1:0] i);
        ent_addr = AW'(int'(g) * NUM_SLOTS + int'(i));
    endfunction

    cfg_t cfg;
    cmp_t cmp;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic             hold_valid_reg, hold_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             dv_reg, dv_next;
    logic [DEPTH-1:0] valid_reg;
    logic [SW-1:0]    soonest_reg [NUM_GROUPS];

    // Request context and scan payload
    logic             op_reg, op_next;
    logic [GW-1:0]    g_reg, g_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [31:0]      now_reg, now_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [31:0]      stamp_rel_reg, stamp_rel_next;
    logic             prev_nz_reg, prev_nz_next;
    logic             prev_sooner_reg, prev_sooner_next;
    logic             found_reg, found_next;
    logic [SW-1:0]    best_reg, best_next;
    logic [31:0]      best_val_reg, best_val_next;
    logic [31:0]      best_rel_reg, best_rel_next;
    logic [CW-1:0]    iss_reg, iss_next;
    logic [SW-1:0]    di_reg, di_next;
    logic             rvalid_reg;
    res_t             hold_reg, hold_next;
    res_t             out_reg, out_next;

    // Memory and update strobes
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr, clr_addr;
    logic [31:0]      ram_rdata, tab_data;
    logic             valid_clr;
    logic             soon_we;
    logic [SW-1:0]    soon_wdata;
    logic             push_en;
    res_t             push_data;
    logic             out_load;
    res_t             out_data;

    // Decode helpers
    logic             acc, out_free;
    logic [SW-1:0]    cur_slot;
    logic [31:0]      mask_sh, map_sh, map_in_sh, sum;
    logic             di_online;
    logic [GW-1:0]    di_group;
    logic             elig, expired, better, scan_done, stall;

    sctm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sctm_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (stamp_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entries never written since reset, or cleared on expiry, read as no event
    assign tab_data = rvalid_reg ? ram_rdata : '0;

    sctm_cmp_unit u_cmp (
        .operand  (tab_data),
        .now      (now_reg),
        .base_rel ((state_reg == ST_SCAN) ? best_rel_reg : stamp_rel_reg),
        .result   (cmp)
    );

    assign req.ready     = (state_reg == ST_IDLE);
    assign acc           = req.valid && req.ready;
    assign res.valid     = out_valid_reg;
    assign res.payload   = out_reg;
    assign out_free      = !out_valid_reg || res.ready;
    assign cur_slot      = soonest_reg[g_reg];
    assign sum           = req.payload.now + req.payload.delta;
    assign map_in_sh     = 32'(cfg.slot_group_map) >> req.payload.slot;

    // Per-slot attributes of the entry under scan; slots past eight are offline, group 0
    assign mask_sh       = 32'(cfg.online_mask) >> di_reg;
    assign map_sh        = 32'(cfg.slot_group_map) >> di_reg;
    assign di_online     = mask_sh[0];
    assign di_group      = (NUM_GROUPS > 1) ? GW'(map_sh[0]) : '0;

    assign scan_done     = !dv_reg && (32'(iss_reg) == NUM_SLOTS);
    assign elig          = dv_reg && di_online && (tab_data != '0)
                           && (op_reg == OP_SET || di_group == g_reg);
    assign expired       = elig && (op_reg == OP_IRQ) && cmp.rel[31];
    assign better        = elig && !expired && (!found_reg || cmp.lt);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        hold_valid_next  = hold_valid_reg;
        out_valid_next   = out_valid_reg;
        dv_next          = dv_reg;
        op_next          = op_reg;
        g_next           = g_reg;
        slot_next        = slot_reg;
        now_next         = now_reg;
        stamp_next       = stamp_reg;
        stamp_rel_next   = stamp_rel_reg;
        prev_nz_next     = prev_nz_reg;
        prev_sooner_next = prev_sooner_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        best_val_next    = best_val_reg;
        best_rel_next    = best_rel_reg;
        iss_next         = iss_reg;
        di_next          = di_reg;
        hold_next        = hold_reg;
        out_next         = out_reg;
        ram_we           = 1'b0;
        ram_waddr        = ent_addr(g_reg, slot_reg);
        ram_re           = 1'b0;
        ram_raddr        = ent_addr(g_reg, slot_reg);
        valid_clr        = 1'b0;
        clr_addr         = ent_addr(g_reg, di_reg);
        soon_we          = 1'b0;
        soon_wdata       = slot_reg;
        push_en          = 1'b0;
        push_data        = '0;
        out_load         = 1'b0;
        out_data         = hold_reg;
        stall            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc && (32'(req.payload.slot) < NUM_SLOTS))
                begin
                    op_next        = req.payload.op;
                    slot_next      = SW'(req.payload.slot);
                    now_next       = req.payload.now;
                    stamp_next     = (sum == '0) ? 32'd1 : sum;
                    stamp_rel_next = (sum == '0) ? req.payload.delta + 32'd1
                                                 : req.payload.delta;
                    found_next     = 1'b0;
                    iss_next       = '0;
                    dv_next        = 1'b0;
                    if (req.payload.op == OP_SET)
                    begin
                        g_next     = (NUM_GROUPS > 1) ? GW'(req.payload.group) : '0;
                        state_next = ST_SET_RDP;
                    end
                    else if (req.payload.timer_pending)
                    begin
                        g_next     = (NUM_GROUPS > 1) ? GW'(map_in_sh[0]) : '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SET_RDP:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ent_addr(g_reg, slot_reg);
                state_next = ST_SET_RDC;
            end

            ST_SET_RDC:
            begin
                // Previous deadline of this slot is on the read port now
                prev_nz_next     = (tab_data != '0);
                prev_sooner_next = cmp.lt;
                ram_re           = 1'b1;
                ram_raddr        = ent_addr(g_reg, cur_slot);
                state_next       = ST_SET_DEC;
            end

            ST_SET_DEC:
            begin
                ram_we    = 1'b1;
                ram_waddr = ent_addr(g_reg, slot_reg);
                if (slot_reg == cur_slot && prev_nz_reg && prev_sooner_reg)
                begin
                    // Soonest slot postponed: rescan the group for the new soonest
                    found_next    = 1'b1;
                    best_next     = slot_reg;
                    best_val_next = stamp_reg;
                    best_rel_next = stamp_rel_reg;
                    iss_next      = '0;
                    dv_next       = 1'b0;
                    state_next    = ST_SCAN;
                end
                else if (tab_data == '0 || cmp.gt)
                begin
                    soon_we                 = 1'b1;
                    soon_wdata              = slot_reg;
                    push_en                 = 1'b1;
                    push_data.kind          = KIND_CMP;
                    push_data.compare_value = stamp_rel_reg[31]
                                              ? now_reg + 32'(stamp_rel_reg[5:0])
                                              : stamp_reg;
                    state_next              = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (!scan_done)
                begin
                    stall = expired && hold_valid_reg && !out_free;
                    if (!stall)
                    begin
                        if (expired)
                        begin
                            valid_clr             = 1'b1;
                            push_en               = 1'b1;
                            push_data.kind        = KIND_FIRE;
                            push_data.target_slot = 3'(di_reg);
                            push_data.by_ipi      = (di_reg != slot_reg);
                        end
                        if (better)
                        begin
                            found_next    = 1'b1;
                            best_next     = di_reg;
                            best_val_next = tab_data;
                            best_rel_next = cmp.rel;
                        end
                        if (32'(iss_reg) < NUM_SLOTS)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = ent_addr(g_reg, SW'(iss_reg));
                            di_next   = SW'(iss_reg);
                            iss_next  = iss_reg + CW'(1);
                            dv_next   = 1'b1;
                        end
                        else
                        begin
                            dv_next = 1'b0;
                        end
                    end
                end
                else if (found_reg)
                begin
                    stall = hold_valid_reg && !out_free;
                    if (!stall)
                    begin
                        soon_we                 = 1'b1;
                        soon_wdata              = best_reg;
                        push_en                 = 1'b1;
                        push_data.kind          = KIND_CMP;
                        push_data.compare_value = best_rel_reg[31]
                                                  ? now_reg + 32'(best_rel_reg[5:0])
                                                  : best_val_reg;
                        state_next              = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                // Release the held result as the final one of this request
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_data        = hold_reg;
                    out_data.last   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new result moves the held one on, which is then known not to be last
        if (push_en)
        begin
            if (hold_valid_reg)
            begin
                out_load      = 1'b1;
                out_data      = hold_reg;
                out_data.last = 1'b0;
            end
            hold_next       = push_data;
            hold_valid_next = 1'b1;
        end

        // Output register
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = out_data;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            dv_reg         <= 1'b0;
            valid_reg      <= '0;
            for (int k = 0; k < NUM_GROUPS; k++)
            begin
                soonest_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            dv_reg         <= dv_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[clr_addr] <= 1'b0;
            end
            if (soon_we)
            begin
                soonest_reg[g_reg] <= soon_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        g_reg           <= g_next;
        slot_reg        <= slot_next;
        now_reg         <= now_next;
        stamp_reg       <= stamp_next;
        stamp_rel_reg   <= stamp_rel_next;
        prev_nz_reg     <= prev_nz_next;
        prev_sooner_reg <= prev_sooner_next;
        found_reg       <= found_next;
        best_reg        <= best_next;
        best_val_reg    <= best_val_next;
        best_rel_reg    <= best_rel_next;
        iss_reg         <= iss_next;
        di_reg          <= di_next;
        hold_reg        <= hold_next;
        out_reg         <= out_next;
        if (ram_re)
        begin
            rvalid_reg <= valid_reg[ram_raddr];
        end
    end

`ifndef SYNTHESIS
    // No result is left held once the sequencer is back in idle.
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !hold_valid_reg)
        else $error("held result left over in idle");

    // The deadline table is written only when a set request decides.
    a_write_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_SET_DEC)
        else $error("table write outside set decision");

    // A rescan after a postponed soonest slot always has a candidate.
    a_set_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && op_reg == OP_SET) |-> found_reg)
        else $error("set rescan without candidate");

    // The soonest slot written back is always a real slot.
    a_soonest_range: assert property (@(posedge clk) disable iff (!rst_n)
        soon_we |-> 32'(soon_wdata) < NUM_SLOTS)
        else $error("soonest slot out of range");

    // An expired entry is cleared in the same cycle its fire result is pushed.
    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push_en && push_data.kind == KIND_FIRE) |-> valid_clr)
        else $error("fire result without clearing its entry");
`endif

endmodule
